[rtl/ctt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, constants and helpers for the clock tick table sync unit.
// ----------------------------------------------------------------------------
package ctt_pkg;

   // table geometry and time width
   localparam int CLOCK_COUNT = 8;
   localparam int TIME_BITS   = 40;
   localparam int IDX_BITS    = $clog2(CLOCK_COUNT);
   localparam int CNT_BITS    = $clog2(CLOCK_COUNT + 1);
   localparam int SHIFT_BITS  = $clog2(TIME_BITS);
   localparam int MASK_BITS   = 8;
   localparam int KIND_BITS   = 2;
   localparam int ACTIVE_BITS = 4;

   // opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_EVENT = 2'd1;
   localparam logic [1:0] OP_SYNC  = 2'd2;

   // clock kinds
   localparam logic [KIND_BITS-1:0] KIND_CONSTANT  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRIGGERED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_OTHER     = 2'd2;

   // register map
   localparam int           CSR_ADDR_BITS   = 3;
   localparam logic [0:0]   REG_ACTIVE_CNT  = 1'b0;

   typedef logic [TIME_BITS-1:0] time_type;

   // one table entry
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      time_type             interval;
      time_type             next_tick;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{kind: KIND_OTHER, interval: '0, next_tick: '0};

   // table write port
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           data;
   } ram_wr_type;

   // GCD unit status
   typedef struct packed {
      logic     done;
      time_type result;
   } gcd_rsp_type;

   typedef enum logic [1:0] {
      G_IDLE,
      G_ALIGN,
      G_REDUCE
   } gcd_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EV_READ,
      ST_EV_UPDATE,
      ST_SY_START,
      ST_SY_READ,
      ST_SY_DATA,
      ST_SY_WAIT,
      ST_FINISH
   } ctt_state_type;

   // add with saturation at the largest time value
   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

endpackage

[rtl/ctt_table_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_table_ram
// Clock table memory: one write port, one registered read port. Per-entry
// valid bits give the reset contents until an entry is first written.
// ----------------------------------------------------------------------------
module ctt_table_ram
   import ctt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ram_wr_type          wr,
   input  logic [IDX_BITS-1:0] rd_addr,
   output entry_type           rd_data
);

   entry_type                  mem [CLOCK_COUNT];
   logic [CLOCK_COUNT-1:0]     valid_ff;
   entry_type                  rd_mem_ff;
   logic                       rd_valid_ff;

   // storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_mem_ff <= mem[rd_addr];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : RESET_ENTRY;

endmodule

[rtl/ctt_gcd_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_gcd_unit
// Iterative binary GCD: one shift or subtract-and-shift per cycle.
// gcd(x, 0) = x. Raises done for one cycle with the result.
// ----------------------------------------------------------------------------
module ctt_gcd_unit
   import ctt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  time_type    op_a,
   input  time_type    op_b,
   output gcd_rsp_type rsp
);

   gcd_state_type          state_ff, state_in;
   time_type               a_ff, a_in;
   time_type               b_ff, b_in;
   logic [SHIFT_BITS-1:0]  k_ff, k_in;
   logic                   done_ff, done_in;
   time_type               result_ff, result_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      result_ff <= result_in;
   end

   // next state and step
   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               a_in     = op_a;
               b_in     = op_b;
               k_in     = '0;
               state_in = G_ALIGN;
            end
         end
         G_ALIGN: begin
            // strip common factors of two
            if (a_ff == '0 || b_ff == '0) begin
               result_in = (a_ff | b_ff) << k_ff;
               done_in   = 1'b1;
               state_in  = G_IDLE;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else begin
               state_in = G_REDUCE;
            end
         end
         G_REDUCE: begin
            if (a_ff == '0 || b_ff == '0) begin
               result_in = (a_ff | b_ff) << k_ff;
               done_in   = 1'b1;
               state_in  = G_IDLE;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

[rtl/clock_tick_table_sync_gcd_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_tick_table_sync_gcd_unit
// Clock tick table with load, event advance and GCD sync point query.
//
//   channel | dir | contents
//   req_    | in  | tuser: opcode; tdata: index, kind, interval, shift, time, step
//   rsp_    | out | tdata: sync point, ticked mask (one transfer per request)
//   csr_    | in  | APB-style, one register: active clock count at 0x0
//
// Load writes one entry. Event reads each of the n active entries in turn,
// n being the active count; sync runs the binary GCD unit, one step per
// cycle, on time and step, then folds in each active non-triggered entry. One
// request at a time. Reset is synchronous and clears the table to its reset
// contents at once. A stalled result sits in the output register; the next
// request is taken meanwhile and waits at its end until that register is free.
// ----------------------------------------------------------------------------
module clock_tick_table_sync_gcd_unit
   import ctt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [167:0]             req_tdata,  // clock_index, clock_kind, interval_us,
                                                // shift_us, time_us, model_step_us, pad
   input  logic [1:0]               req_tuser,  // opcode
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,  // sync_point_us, ticked_mask
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   ctt_state_type           state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [2:0]              idx_ff, idx_in;
   logic [KIND_BITS-1:0]    kind_ff, kind_in;
   time_type                interval_ff, interval_in;
   time_type                shift_ff, shift_in;
   time_type                time_ff, time_in;
   time_type                step_ff, step_in;
   time_type                acc_ff, acc_in;
   logic [MASK_BITS-1:0]    mask_ff, mask_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [ACTIVE_BITS-1:0]  active_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [47:0]             rsp_data_ff, rsp_data_in;

   logic [CNT_BITS-1:0]     n_eff;
   logic                    req_fire;
   logic                    csr_write;
   ram_wr_type              ram_wr;
   logic [IDX_BITS-1:0]     ram_rd_addr;
   entry_type               ram_rd;
   logic                    gcd_start;
   time_type                gcd_a;
   time_type                gcd_b;
   gcd_rsp_type             gcd_rsp;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_write && csr_paddr[2] == REG_ACTIVE_CNT) begin
         active_ff <= csr_pwdata[ACTIVE_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_CNT) ?
                       {{(32-ACTIVE_BITS){1'b0}}, active_ff} : '0;

   // active entries, clamped to the table size
   assign n_eff = (int'(active_ff) > CLOCK_COUNT) ? CNT_BITS'(CLOCK_COUNT)
                                                  : CNT_BITS'(active_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   // table and GCD unit
   ctt_table_ram u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd)
   );

   ctt_gcd_unit u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .op_a  (gcd_a),
      .op_b  (gcd_b),
      .rsp   (gcd_rsp)
   );

   assign ram_rd_addr = cnt_ff[IDX_BITS-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      interval_ff <= interval_in;
      shift_ff    <= shift_in;
      time_ff     <= time_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      interval_in  = interval_ff;
      shift_in     = shift_ff;
      time_in      = time_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_wr       = '0;
      gcd_start    = 1'b0;
      gcd_a        = acc_ff;
      gcd_b        = ram_rd.next_tick;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_tuser;
               idx_in      = req_tdata[2:0];
               kind_in     = req_tdata[4:3];
               interval_in = req_tdata[44:5];
               shift_in    = req_tdata[84:45];
               time_in     = req_tdata[124:85];
               step_in     = req_tdata[164:125];
               acc_in      = '0;
               mask_in     = '0;
               cnt_in      = '0;
               case (req_tuser)
                  OP_LOAD:  state_in = ST_LOAD;
                  OP_EVENT: state_in = ST_EV_READ;
                  OP_SYNC:  state_in = ST_SY_START;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_LOAD: begin
            if (int'(idx_ff) < CLOCK_COUNT) begin
               ram_wr.en             = 1'b1;
               ram_wr.addr           = idx_ff[IDX_BITS-1:0];
               ram_wr.data.kind      = kind_ff;
               ram_wr.data.interval  = interval_ff;
               ram_wr.data.next_tick = sat_add(time_ff, shift_ff);
            end
            state_in = ST_FINISH;
         end
         // event: read entry, then compare and advance
         ST_EV_READ: begin
            state_in = (cnt_ff == n_eff) ? ST_FINISH : ST_EV_UPDATE;
         end
         ST_EV_UPDATE: begin
            if (ram_rd.kind == KIND_CONSTANT && ram_rd.next_tick == time_ff) begin
               ram_wr.en             = 1'b1;
               ram_wr.addr           = cnt_ff[IDX_BITS-1:0];
               ram_wr.data.kind      = ram_rd.kind;
               ram_wr.data.interval  = ram_rd.interval;
               ram_wr.data.next_tick = sat_add(ram_rd.next_tick, ram_rd.interval);
               if (int'(cnt_ff) < MASK_BITS) begin
                  mask_in[cnt_ff[2:0]] = 1'b1;
               end
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_EV_READ;
         end
         // sync: gcd of time and step, then fold in each non-triggered entry
         ST_SY_START: begin
            gcd_start = 1'b1;
            gcd_a     = time_ff;
            gcd_b     = step_ff;
            state_in  = ST_SY_WAIT;
         end
         ST_SY_WAIT: begin
            if (gcd_rsp.done) begin
               acc_in   = gcd_rsp.result;
               state_in = ST_SY_READ;
            end
         end
         ST_SY_READ: begin
            state_in = (cnt_ff == n_eff) ? ST_FINISH : ST_SY_DATA;
         end
         ST_SY_DATA: begin
            cnt_in = cnt_ff + 1'b1;
            if (ram_rd.kind != KIND_TRIGGERED) begin
               gcd_start = 1'b1;
               state_in  = ST_SY_WAIT;
            end else begin
               state_in  = ST_SY_READ;
            end
         end
         ST_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (op_ff == OP_SYNC) begin
                  rsp_data_in[39:0] = acc_ff;
               end
               if (op_ff == OP_EVENT) begin
                  rsp_data_in[47:40] = mask_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
